// ----- src/mfu_page_frame_replacer_top_assert.svh -----
// ----------------------------------------------------------------------------
// mfu page frame replacer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MFU_PAGE_FRAME_REPLACER_TOP_ASSERT_SVH
`define MFU_PAGE_FRAME_REPLACER_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define MPFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define MPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfr_pkg
// shared constants and types of the mfu page frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

package mpfr_pkg;

    // default sizes
    localparam int FRAMES_DEF     = 4;
    localparam int PAGE_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    // fixed port field widths
    localparam int PAGE_FIELD_W  = 8;
    localparam int FRAME_FIELD_W = 2;
    localparam int FAULT_W       = 32;

    // control flags of the scan token passed along the cell row
    typedef struct packed {
        logic valid;
        logic found;
        logic empty;
        logic max_set;
    } t_scan_flags;

    // frame update command broadcast to the cells
    typedef struct packed {
        logic en;
        logic replace;
    } t_upd_cmd;

endpackage

`default_nettype wire

// ----- src/mpfr_cell.sv -----
// ----------------------------------------------------------------------------
// mpfr_cell
// one frame: holds page, valid mark and use count, merges the scan token
// ----------------------------------------------------------------------------
`default_nettype none

module mpfr_cell #(
    parameter int FRAMES     = mpfr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = mpfr_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = mpfr_pkg::COUNT_BITS_DEF,
    parameter int CELL_ID    = 0,
    localparam int IDX_W     = $clog2(FRAMES)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // token from the left neighbor
    input  mpfr_pkg::t_scan_flags      i_flags,
    input  wire [PAGE_BITS-1:0]        i_page,
    input  wire [IDX_W-1:0]            i_found_idx,
    input  wire [IDX_W-1:0]            i_empty_idx,
    input  wire [IDX_W-1:0]            i_max_idx,
    input  wire [COUNT_BITS-1:0]       i_max_cnt,
    input  wire [PAGE_BITS-1:0]        i_max_page,
    // token to the right neighbor
    output mpfr_pkg::t_scan_flags      o_flags,
    output logic [PAGE_BITS-1:0]       o_page,
    output logic [IDX_W-1:0]           o_found_idx,
    output logic [IDX_W-1:0]           o_empty_idx,
    output logic [IDX_W-1:0]           o_max_idx,
    output logic [COUNT_BITS-1:0]      o_max_cnt,
    output logic [PAGE_BITS-1:0]       o_max_page,
    // update broadcast
    input  mpfr_pkg::t_upd_cmd         i_upd,
    input  wire [IDX_W-1:0]            i_upd_idx,
    input  wire [PAGE_BITS-1:0]        i_upd_page
);
    import mpfr_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic                  r_valid;
    logic [PAGE_BITS-1:0]  r_page;
    logic [COUNT_BITS-1:0] r_count;

    t_scan_flags           r_flags;
    logic [PAGE_BITS-1:0]  r_tok_page;
    logic [IDX_W-1:0]      r_found_idx;
    logic [IDX_W-1:0]      r_empty_idx;
    logic [IDX_W-1:0]      r_max_idx;
    logic [COUNT_BITS-1:0] r_max_cnt;
    logic [PAGE_BITS-1:0]  r_max_page;

    logic match;
    logic take_max;
    logic sel;

    assign match    = r_valid && (r_page == i_page);
    assign take_max = !i_flags.max_set || (r_count > i_max_cnt);
    assign sel      = i_upd.en && (i_upd_idx == MY_IDX);

    // frame contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_page  <= '0;
            r_count <= '0;
        end else if (sel) begin
            if (i_upd.replace) begin
                r_valid <= 1'b1;
                r_page  <= i_upd_page;
                r_count <= '0;
            end else if (!(&r_count)) begin
                // saturate at all ones
                r_count <= r_count + 1'b1;
            end
        end
    end

    // token flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.valid   <= i_flags.valid;
            r_flags.found   <= i_flags.found | match;
            r_flags.empty   <= i_flags.empty | !r_valid;
            r_flags.max_set <= 1'b1;
        end
    end

    // token payload, first match and first empty win
    always_ff @(posedge i_clk) begin
        r_tok_page  <= i_page;
        r_found_idx <= i_flags.found ? i_found_idx : MY_IDX;
        r_empty_idx <= i_flags.empty ? i_empty_idx : MY_IDX;
        r_max_idx   <= take_max ? MY_IDX  : i_max_idx;
        r_max_cnt   <= take_max ? r_count : i_max_cnt;
        r_max_page  <= take_max ? r_page  : i_max_page;
    end

    assign o_flags     = r_flags;
    assign o_page      = r_tok_page;
    assign o_found_idx = r_found_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_max_idx   = r_max_idx;
    assign o_max_cnt   = r_max_cnt;
    assign o_max_page  = r_max_page;

endmodule

`default_nettype wire

// ----- src/mpfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpfr_ctrl
// item sequencing, replacement decision, fault counter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module mpfr_ctrl #(
    parameter int FRAMES     = mpfr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = mpfr_pkg::PAGE_BITS_DEF,
    localparam int IDX_W     = $clog2(FRAMES)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    // token leaving the last cell
    input  mpfr_pkg::t_scan_flags                i_last_flags,
    input  wire [PAGE_BITS-1:0]                  i_last_page,
    input  wire [IDX_W-1:0]                      i_last_found_idx,
    input  wire [IDX_W-1:0]                      i_last_empty_idx,
    input  wire [IDX_W-1:0]                      i_last_max_idx,
    input  wire [PAGE_BITS-1:0]                  i_last_max_page,
    // update broadcast
    output mpfr_pkg::t_upd_cmd                   o_upd,
    output logic [IDX_W-1:0]                     o_upd_idx,
    output logic [PAGE_BITS-1:0]                 o_upd_page,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_hit,
    output logic [mpfr_pkg::FRAME_FIELD_W-1:0]   o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [mpfr_pkg::PAGE_FIELD_W-1:0]    o_evicted_page,
    output logic [mpfr_pkg::FAULT_W-1:0]         o_fault_total
);
    import mpfr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;

    logic                 r_dec_hit;
    logic                 r_dec_evict;
    logic [IDX_W-1:0]     r_dec_slot;
    logic [PAGE_BITS-1:0] r_dec_page;
    logic [PAGE_BITS-1:0] r_dec_ev_page;

    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   n_fault;

    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [FRAME_FIELD_W-1:0]   r_out_frame;
    logic                       r_out_ev_valid;
    logic [PAGE_FIELD_W-1:0]    r_out_ev_page;
    logic [FAULT_W-1:0]         r_out_fault;

    logic                 in_accept;
    logic                 scan_done;
    logic                 out_free;
    logic                 commit;
    logic                 dec_evict;
    logic [IDX_W-1:0]     dec_slot;
    logic [IDX_W+FRAME_FIELD_W-1:0] slot_ext;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign scan_done = (r_state == ST_SCAN) && i_last_flags.valid;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign commit    = (r_state == ST_COMMIT) && out_free;

    // hit, else lowest empty, else greatest count
    assign dec_evict = !i_last_flags.found && !i_last_flags.empty;
    assign dec_slot  = i_last_flags.found ? i_last_found_idx :
                       i_last_flags.empty ? i_last_empty_idx : i_last_max_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_accept) n_state = ST_SCAN;
            ST_SCAN:   if (scan_done) n_state = ST_COMMIT;
            ST_COMMIT: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            r_dec_hit     <= i_last_flags.found;
            r_dec_evict   <= dec_evict;
            r_dec_slot    <= dec_slot;
            r_dec_page    <= i_last_page;
            r_dec_ev_page <= dec_evict ? i_last_max_page : '0;
        end
    end

    assign n_fault = r_fault + FAULT_W'(!r_dec_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (commit) begin
            r_fault <= n_fault;
        end
    end

    assign slot_ext = {{FRAME_FIELD_W{1'b0}}, r_dec_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_hit      <= r_dec_hit;
            r_out_frame    <= slot_ext[FRAME_FIELD_W-1:0];
            r_out_ev_valid <= r_dec_evict;
            r_out_ev_page  <= PAGE_FIELD_W'(r_dec_ev_page);
            r_out_fault    <= n_fault;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_upd.en        = commit;
    assign o_upd.replace   = !r_dec_hit;
    assign o_upd_idx       = r_dec_slot;
    assign o_upd_page      = r_dec_page;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_frame;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_fault;

endmodule

`default_nettype wire

// ----- src/mfu_page_frame_replacer_top.sv -----
// ----------------------------------------------------------------------------
// mfu_page_frame_replacer_top
// most-frequently-used page frame replacer built as a row of frame cells
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_page
//  out      output     o_out_valid / i_out_stall o_hit, o_frame_index,
//                                                o_evicted_valid, o_evicted_page,
//                                                o_fault_total
//
//  for each item a scan token walks the cell row one cell per cycle, then
//  the decision is registered and then committed
//  the next item is taken only after the frame update has landed
//  a finished result sits in the output register while the next item scans
//  a stalled output holds the commit, and with it the input, until taken
//  reset (synchronous, active low) empties all frames and zeroes the fault count
// ----------------------------------------------------------------------------
`default_nettype none

module mfu_page_frame_replacer_top #(
    parameter int FRAMES     = mpfr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = mpfr_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = mpfr_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // request channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire [mpfr_pkg::PAGE_FIELD_W-1:0]     i_page,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_hit,
    output logic [mpfr_pkg::FRAME_FIELD_W-1:0]   o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [mpfr_pkg::PAGE_FIELD_W-1:0]    o_evicted_page,
    output logic [mpfr_pkg::FAULT_W-1:0]         o_fault_total
);
    import mpfr_pkg::*;

    localparam int IDX_W = $clog2(FRAMES);

    // token chain, entry 0 is the seed, entry k+1 leaves cell k
    t_scan_flags           tok_flags     [FRAMES+1];
    logic [PAGE_BITS-1:0]  tok_page      [FRAMES+1];
    logic [IDX_W-1:0]      tok_found_idx [FRAMES+1];
    logic [IDX_W-1:0]      tok_empty_idx [FRAMES+1];
    logic [IDX_W-1:0]      tok_max_idx   [FRAMES+1];
    logic [COUNT_BITS-1:0] tok_max_cnt   [FRAMES+1];
    logic [PAGE_BITS-1:0]  tok_max_page  [FRAMES+1];

    t_upd_cmd              upd;
    logic [IDX_W-1:0]      upd_idx;
    logic [PAGE_BITS-1:0]  upd_page;

    // seed token: only carries the request, nothing found yet
    assign tok_flags[0]     = t_scan_flags'{valid:   i_in_valid && !o_in_stall,
                                            found:   1'b0,
                                            empty:   1'b0,
                                            max_set: 1'b0};
    assign tok_page[0]      = PAGE_BITS'(i_page);
    assign tok_found_idx[0] = '0;
    assign tok_empty_idx[0] = '0;
    assign tok_max_idx[0]   = '0;
    assign tok_max_cnt[0]   = '0;
    assign tok_max_page[0]  = '0;

    // row of frame cells, each looks at the token once as it passes
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        mpfr_cell #(
            .FRAMES     (FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .CELL_ID    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_flags     (tok_flags[g]),
            .i_page      (tok_page[g]),
            .i_found_idx (tok_found_idx[g]),
            .i_empty_idx (tok_empty_idx[g]),
            .i_max_idx   (tok_max_idx[g]),
            .i_max_cnt   (tok_max_cnt[g]),
            .i_max_page  (tok_max_page[g]),
            .o_flags     (tok_flags[g+1]),
            .o_page      (tok_page[g+1]),
            .o_found_idx (tok_found_idx[g+1]),
            .o_empty_idx (tok_empty_idx[g+1]),
            .o_max_idx   (tok_max_idx[g+1]),
            .o_max_cnt   (tok_max_cnt[g+1]),
            .o_max_page  (tok_max_page[g+1]),
            .i_upd       (upd),
            .i_upd_idx   (upd_idx),
            .i_upd_page  (upd_page)
        );
    end

    // decision, commit and result register
    mpfr_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_last_flags     (tok_flags[FRAMES]),
        .i_last_page      (tok_page[FRAMES]),
        .i_last_found_idx (tok_found_idx[FRAMES]),
        .i_last_empty_idx (tok_empty_idx[FRAMES]),
        .i_last_max_idx   (tok_max_idx[FRAMES]),
        .i_last_max_page  (tok_max_page[FRAMES]),
        .o_upd            (upd),
        .o_upd_idx        (upd_idx),
        .o_upd_page       (upd_page),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_frame_index    (o_frame_index),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_total    (o_fault_total)
    );

    // the final max count is only needed inside the row
    logic unused_max_cnt;
    assign unused_max_cnt = ^tok_max_cnt[FRAMES];

endmodule

`default_nettype wire

// ----- src/mpfr_checker.sv -----
// ----------------------------------------------------------------------------
// mpfr_checker
// port level checks of the mfu page frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

`include "mfu_page_frame_replacer_top_assert.svh"

module mpfr_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  o_in_stall,
    input  wire [mpfr_pkg::PAGE_FIELD_W-1:0]     i_page,
    input  wire                                  o_out_valid,
    input  wire                                  i_out_stall,
    input  wire                                  o_hit,
    input  wire [mpfr_pkg::FRAME_FIELD_W-1:0]    o_frame_index,
    input  wire                                  o_evicted_valid,
    input  wire [mpfr_pkg::PAGE_FIELD_W-1:0]     o_evicted_page,
    input  wire [mpfr_pkg::FAULT_W-1:0]          o_fault_total
);
    logic unused_in;
    assign unused_in = ^i_page;

    // a stalled result keeps its payload
    `MPFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_hit) && $stable(o_frame_index) &&
        $stable(o_evicted_valid) && $stable(o_evicted_page) && $stable(o_fault_total),
        "stalled result changed")

    // one item at a time: after an accept the input stalls
    `MPFR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "second item taken while one is in flight")

    // a hit never evicts
    `MPFR_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, o_out_valid && o_hit,
        !o_evicted_valid, "eviction reported on a hit")

    // no eviction means a zero evicted page
    `MPFR_ASSERT_NOW(a_evict_page_zero, i_clk, i_rst_n, o_out_valid && !o_evicted_valid,
        o_evicted_page == '0, "evicted page not zero without eviction")

endmodule

bind mfu_page_frame_replacer_top mpfr_checker u_mpfr_checker (.*);

`default_nettype wire
